// ===== sv/tasp_pkg.sv =====
package tasp_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int TICK_US      = 1;
	localparam int RELOAD_BITS  = 16;
	localparam int COUNT_BITS   = 32;
	localparam int HALF_BITS    = COUNT_BITS + 1;
	localparam int PERIOD_BITS  = 32;
	localparam int FUNC_BITS    = 2;
	localparam int MOTOR_BITS   = 2;
	localparam int RELOAD_DIV   = 2 * TICK_US;

	localparam logic [RELOAD_BITS-1:0] RELOAD_MAX = {RELOAD_BITS{1'b1}};

	localparam logic [FUNC_BITS-1:0] FUNC_TICK = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_MOVE = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_STOP = 2'd2;

	typedef struct packed {
		logic tick;
		logic move;
		logic stop;
	} chan_cmd_t;

	typedef struct packed {
		logic                        dir;
		logic                        start_ok;
		logic [RELOAD_BITS-1:0]      reload;
		logic signed [HALF_BITS-1:0] half;
	} move_data_t;

	typedef struct packed {
		logic                        running;
		logic                        step;
		logic                        dir;
		logic [RELOAD_BITS-1:0]      reload;
		logic [RELOAD_BITS-1:0]      cnt;
		logic signed [HALF_BITS-1:0] half;
	} chan_state_t;

endpackage

// ===== sv/three_axis_step_pulse_generator_unit.sv =====
// A transaction is captured in the input register, which feeds channel update and report logic;
// its result is registered in the output stage. One transaction per cycle unless the input stalls.
// A stalled result holds the pipeline; the input side stalls only when both stages are full
// and the result is stalled.
// Reset: arst_n asynchronously clears all channel state (stopped, step and dir bits low) and both valid flags.
module three_axis_step_pulse_generator_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic [tasp_pkg::FUNC_BITS-1:0]         func,
	input  logic [tasp_pkg::MOTOR_BITS-1:0]        motor,
	input  logic                                   direction,
	input  logic [tasp_pkg::PERIOD_BITS-1:0]       pulse_period_us,
	input  logic signed [tasp_pkg::COUNT_BITS-1:0] move_steps,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic [tasp_pkg::NUM_CHANNELS-1:0]      step_pins,
	output logic [tasp_pkg::NUM_CHANNELS-1:0]      dir_pins,
	output logic [tasp_pkg::NUM_CHANNELS-1:0]      running_mask,
	output logic                                   any_moving,
	output logic signed [tasp_pkg::COUNT_BITS-1:0] remaining_steps
);

	logic                                   valid_s1;
	logic [tasp_pkg::FUNC_BITS-1:0]         func_s1;
	logic [tasp_pkg::MOTOR_BITS-1:0]        motor_s1;
	logic                                   dir_s1;
	logic [tasp_pkg::PERIOD_BITS-1:0]       period_s1;
	logic signed [tasp_pkg::COUNT_BITS-1:0] count_s1;

	logic adv;

	tasp_pkg::move_data_t                    mv;
	tasp_pkg::chan_state_t                   nxt [tasp_pkg::NUM_CHANNELS];
	logic [tasp_pkg::PERIOD_BITS-1:0]        quot;

	logic [tasp_pkg::NUM_CHANNELS-1:0]       step_d;
	logic [tasp_pkg::NUM_CHANNELS-1:0]       dir_d;
	logic [tasp_pkg::NUM_CHANNELS-1:0]       run_d;
	logic                                    any_d;
	logic signed [tasp_pkg::COUNT_BITS-1:0]  rem_d;

	logic                                    out_valid_q;
	logic [tasp_pkg::NUM_CHANNELS-1:0]       step_q;
	logic [tasp_pkg::NUM_CHANNELS-1:0]       dir_q;
	logic [tasp_pkg::NUM_CHANNELS-1:0]       run_q;
	logic                                    any_q;
	logic signed [tasp_pkg::COUNT_BITS-1:0]  rem_q;

	assign adv        = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			func_s1   <= func;
			motor_s1  <= motor;
			dir_s1    <= direction;
			period_s1 <= pulse_period_us;
			count_s1  <= move_steps;
		end
	end

	// reload = period / (2 * tick), saturated
	always_comb begin
		quot        = period_s1 / tasp_pkg::PERIOD_BITS'(tasp_pkg::RELOAD_DIV);
		mv.dir      = dir_s1;
		mv.start_ok = (period_s1 != '0);
		mv.half     = {count_s1, 1'b0};
		if (quot > tasp_pkg::PERIOD_BITS'(tasp_pkg::RELOAD_MAX)) begin
			mv.reload = tasp_pkg::RELOAD_MAX;
		end else begin
			mv.reload = quot[tasp_pkg::RELOAD_BITS-1:0];
		end
	end

	for (genvar i = 0; i < tasp_pkg::NUM_CHANNELS; i++) begin : g_chan
		tasp_pkg::chan_cmd_t cmd;
		logic                sel;

		assign sel      = (tasp_pkg::MOTOR_BITS'(i) == motor_s1);
		assign cmd.tick = (func_s1 == tasp_pkg::FUNC_TICK);
		assign cmd.move = (func_s1 == tasp_pkg::FUNC_MOVE) && sel;
		assign cmd.stop = (func_s1 == tasp_pkg::FUNC_STOP) && sel;

		tasp_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.cmd    (cmd),
			.mv     (mv),
			.nxt    (nxt[i])
		);
	end

	tasp_report u_report (
		.motor           (motor_s1),
		.st              (nxt),
		.step_pins       (step_d),
		.dir_pins        (dir_d),
		.running_mask    (run_d),
		.any_moving      (any_d),
		.remaining_steps (rem_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_q <= step_d;
			dir_q  <= dir_d;
			run_q  <= run_d;
			any_q  <= any_d;
			rem_q  <= rem_d;
		end
	end

	assign result_valid    = out_valid_q;
	assign step_pins       = step_q;
	assign dir_pins        = dir_q;
	assign running_mask    = run_q;
	assign any_moving      = any_q;
	assign remaining_steps = rem_q;

	a_any_moving: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (any_moving == (running_mask != '0)))
		else $error("any_moving disagrees with running_mask");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall && valid_s1))
		else $error("input stalled while pipeline not full");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid)
		else $error("advanced transaction produced no result");

endmodule

// ===== sv/tasp_chan.sv =====
module tasp_chan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  tasp_pkg::chan_cmd_t  cmd,
	input  tasp_pkg::move_data_t mv,
	output tasp_pkg::chan_state_t nxt
);

	tasp_pkg::chan_state_t st_q;

	always_comb begin
		nxt = st_q;
		if (cmd.tick) begin
			if (st_q.running) begin
				if (st_q.cnt >= st_q.reload) begin
					nxt.cnt = '0;
					if (st_q.half != '0) begin
						nxt.step = ~st_q.step;
						if (!st_q.half[tasp_pkg::HALF_BITS-1]) begin
							nxt.half = st_q.half - tasp_pkg::HALF_BITS'(1);
						end
					end else begin
						nxt.step    = 1'b0;
						nxt.running = 1'b0;
					end
				end else begin
					nxt.cnt = st_q.cnt + tasp_pkg::RELOAD_BITS'(1);
				end
			end
		end else if (cmd.move) begin
			nxt.dir    = mv.dir;
			nxt.reload = mv.reload;
			nxt.half   = mv.half;
			if (!st_q.running && mv.start_ok) begin
				nxt.running = 1'b1;
				nxt.cnt     = '0;
			end
		end else if (cmd.stop) begin
			nxt.running = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= nxt;
		end
	end

endmodule

// ===== sv/tasp_report.sv =====
module tasp_report (
	input  logic [tasp_pkg::MOTOR_BITS-1:0]  motor,
	input  tasp_pkg::chan_state_t            st [tasp_pkg::NUM_CHANNELS],
	output logic [tasp_pkg::NUM_CHANNELS-1:0] step_pins,
	output logic [tasp_pkg::NUM_CHANNELS-1:0] dir_pins,
	output logic [tasp_pkg::NUM_CHANNELS-1:0] running_mask,
	output logic                              any_moving,
	output logic signed [tasp_pkg::COUNT_BITS-1:0] remaining_steps
);

	logic                                  motor_ok;
	logic signed [tasp_pkg::HALF_BITS-1:0] h;
	logic signed [tasp_pkg::HALF_BITS-1:0] h_shr;
	logic signed [tasp_pkg::HALF_BITS-1:0] h_adj;

	always_comb begin
		for (int i = 0; i < tasp_pkg::NUM_CHANNELS; i++) begin
			step_pins[i]    = st[i].step;
			dir_pins[i]     = st[i].dir;
			running_mask[i] = st[i].running;
		end
		any_moving = |running_mask;
	end

	assign motor_ok = (32'(motor) < 32'(tasp_pkg::NUM_CHANNELS));

	always_comb begin
		h = '0;
		for (int i = 0; i < tasp_pkg::NUM_CHANNELS; i++) begin
			if (tasp_pkg::MOTOR_BITS'(i) == motor) begin
				h = st[i].half;
			end
		end
		h_shr = h >>> 1;
		h_adj = h_shr + tasp_pkg::HALF_BITS'(1);
	end

	always_comb begin
		priority if (!motor_ok) begin
			remaining_steps = '0;
		end else if (h == tasp_pkg::HALF_BITS'(1) || h == {tasp_pkg::HALF_BITS{1'b1}}) begin
			remaining_steps = h[tasp_pkg::COUNT_BITS-1:0];
		end else if (h[tasp_pkg::HALF_BITS-1] && h[0]) begin
			remaining_steps = h_adj[tasp_pkg::COUNT_BITS-1:0];
		end else begin
			remaining_steps = h_shr[tasp_pkg::COUNT_BITS-1:0];
		end
	end

endmodule
